@@ design/arqr_pkg.sv @@
// arqr_pkg: shared types and constants for the arq receiver
// no dependencies
package arqr_pkg;
  localparam logic [1:0] MODE_SW = 2'd0;
  localparam logic [1:0] MODE_GBN = 2'd1;
  localparam logic [1:0] MODE_SR = 2'd2;
  localparam logic [2:0] SCH_SUM = 3'd0;
  localparam logic [2:0] SCH_CRC8 = 3'd1;
  localparam logic [2:0] SCH_CRC10 = 3'd2;
  localparam logic [2:0] SCH_CRC16 = 3'd3;
  localparam logic [2:0] SCH_CRC32 = 3'd4;
  localparam logic [1:0] KIND_ACK = 2'd0;
  localparam logic [1:0] KIND_NAK = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_SCHEME = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  // frame check verdict handed to the arq engine
  typedef struct packed {
    logic       done;
    logic       good;
    logic [7:0] seq;
  } frame_end_t;

  // one message-bit step of the crc shift register
  function automatic logic [31:0] crc_bit(input logic [31:0] r, input logic b,
                                          input logic [2:0] sch);
    logic [31:0] n;
    logic top;
    begin
      n = 32'd0;
      top = 1'b0;
      case (sch)
        SCH_CRC8: begin
          top = r[7];
          n = {24'd0, r[6:0], b} ^ (top ? 32'h0d5 : 32'd0);
        end
        SCH_CRC10: begin
          top = r[9];
          n = {22'd0, r[8:0], b} ^ (top ? 32'h232 : 32'd0);
        end
        SCH_CRC16: begin
          top = r[15];
          n = {16'd0, r[14:0], b} ^ (top ? 32'h8005 : 32'd0);
        end
        SCH_CRC32: begin
          top = r[31];
          n = {r[30:0], b} ^ (top ? 32'h04c11db7 : 32'd0);
        end
        default: n = r;
      endcase
      return n;
    end
  endfunction
endpackage

@@ design/arqr_check.sv @@
// arqr_check: byte-wise checksum/crc accumulation and frame verdict
// depends on arqr_pkg
module arqr_check #(
  parameter int SEQ_BYTE_POS = 14,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [2:0]           check_scheme,
  output arqr_pkg::frame_end_t fe
);
  import arqr_pkg::*;
  localparam int IW = $clog2(MAX_FRAME_BYTES + 1);

  logic [31:0] crc;
  logic [15:0] sum, held;
  logic [IW-1:0] idx;
  logic [7:0] fseq;

  logic [31:0] crc_next;
  logic [15:0] sum_next, addend;
  logic [16:0] s17;
  logic good_now;

  always_comb begin
    crc_next = crc;
    for (int i = 0; i < 8; i++) crc_next = crc_bit(crc_next, data_byte[7-i], check_scheme);
    addend = idx[0] ? {8'd0, held[15:8]} : {held[15:8], 8'd0};
    s17 = {1'b0, sum} + {1'b0, addend};
    sum_next = (idx >= IW'(2)) ? (s17[15:0] + {15'd0, s17[16]}) : sum;
    good_now = (idx >= IW'(SEQ_BYTE_POS)) && (idx >= IW'(1)) && (idx < IW'(MAX_FRAME_BYTES));
    if (check_scheme == SCH_SUM) good_now = good_now && (~sum_next == {held[7:0], data_byte});
    else if (check_scheme <= SCH_CRC32) good_now = good_now && (crc_next == 32'd0);
    else good_now = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0; sum <= '0; held <= '0; idx <= '0; fseq <= '0; fe <= '0;
    end else begin
      fe.done <= 1'b0;
      if (byte_valid) begin
        if (last_byte) begin
          fe.done <= 1'b1;
          fe.good <= good_now;
          fe.seq <= (idx == IW'(SEQ_BYTE_POS)) ? data_byte : fseq;
          crc <= '0; sum <= '0; held <= '0; idx <= '0; fseq <= '0;
        end else begin
          crc <= crc_next;
          sum <= sum_next;
          held <= {held[7:0], data_byte};
          if (idx == IW'(SEQ_BYTE_POS)) fseq <= data_byte;
          if (idx < IW'(MAX_FRAME_BYTES)) idx <= idx + IW'(1);
        end
      end
    end
  end
endmodule

@@ design/arqr_engine.sv @@
// arqr_engine: arq receiver rules over a received-map memory
// depends on arqr_pkg
module arqr_engine #(
  parameter int SEQ_SPACE = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  arqr_pkg::frame_end_t fe,
  input  logic [1:0]           arq_mode,
  input  logic [7:0]           window_size,
  output logic                 busy,
  output logic                 res_valid,
  input  logic                 res_taken,
  output logic [1:0]           reply_kind,
  output logic [7:0]           reply_seq,
  output logic                 frame_good,
  output logic [7:0]           delivered_first,
  output logic [7:0]           delivered_count
);
  import arqr_pkg::*;
  localparam int SW = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_TEST, S_OUT} st_t;
  st_t st;
  logic map_mem [SEQ_SPACE];
  logic rd_data;
  logic [SW-1:0] expected, raddr, clr_addr;
  logic [7:0] count;
  logic wen, wdat;
  logic [SW-1:0] waddr;

  logic [8:0] wcap;
  logic [8:0] seq_off;
  logic in_win;
  logic [SW-1:0] exp_inc, raddr_inc;
  logic map_hit;
  always_comb begin
    wcap = (window_size > 8'd128) ? 9'd128 : {1'b0, window_size};
    if (wcap > 9'(SEQ_SPACE)) wcap = 9'(SEQ_SPACE);
    seq_off = {1'b0, fe.seq} + 9'(SEQ_SPACE) - 9'(expected);
    if (seq_off >= 9'(SEQ_SPACE)) seq_off = seq_off - 9'(SEQ_SPACE);
    in_win = ({1'b0, fe.seq} < 9'(SEQ_SPACE)) && (seq_off < wcap);
    exp_inc = (9'(expected) == 9'(SEQ_SPACE - 1)) ? '0 : expected + SW'(1);
    raddr_inc = (9'(raddr) == 9'(SEQ_SPACE - 1)) ? '0 : raddr + SW'(1);
    // the mark written on entry to the walk is not yet seen by the first read
    map_hit = rd_data || ((count == 8'd0) && (waddr == raddr));
  end

  always_ff @(posedge clk) begin
    if (wen) map_mem[waddr] <= wdat;
    rd_data <= map_mem[raddr];
  end

  // a waiting result also holds off the next frame end
  assign busy = (st != S_IDLE) || res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR; clr_addr <= '0; expected <= '0; res_valid <= 1'b0;
      wen <= 1'b0; raddr <= '0; count <= '0;
    end else begin
      wen <= 1'b0;
      if (res_valid && res_taken) res_valid <= 1'b0;
      unique case (st)
        S_CLR: begin
          wen <= 1'b1; waddr <= clr_addr; wdat <= 1'b0;
          clr_addr <= clr_addr + SW'(1);
          if (clr_addr == SW'(SEQ_SPACE - 1)) st <= S_IDLE;
        end
        S_IDLE: if (fe.done) begin
          frame_good <= fe.good; reply_kind <= KIND_NONE; reply_seq <= '0;
          delivered_first <= '0; delivered_count <= '0;
          st <= S_OUT;
          if (arq_mode == MODE_SW) begin
            reply_kind <= KIND_ACK;
            if (fe.good) begin
              reply_seq <= fe.seq; delivered_first <= fe.seq; delivered_count <= 8'd1;
              expected <= SW'({7'd0, ~expected[0]});
            end else reply_seq <= {7'd0, ~expected[0]};
          end else if (arq_mode == MODE_GBN) begin
            reply_kind <= KIND_ACK;
            if (fe.good && {1'b0, fe.seq} == 9'(expected)) begin
              delivered_first <= fe.seq; delivered_count <= 8'd1;
              expected <= exp_inc;
              reply_seq <= 8'(exp_inc);
            end else reply_seq <= 8'(expected);
          end else if (arq_mode == MODE_SR) begin
            reply_seq <= fe.seq;
            if (!fe.good) reply_kind <= KIND_NAK;
            else begin
              reply_kind <= KIND_ACK;
              if (in_win) begin
                wen <= 1'b1; waddr <= SW'(fe.seq); wdat <= 1'b1;
                delivered_first <= 8'(expected);
                count <= '0; raddr <= expected;
                st <= S_READ;
              end
            end
          end
        end
        S_READ: st <= S_TEST;
        S_TEST: begin
          if (map_hit && count < 8'd128) begin
            wen <= 1'b1; waddr <= raddr; wdat <= 1'b0;
            count <= count + 8'd1;
            expected <= raddr_inc;
            raddr <= raddr_inc;
            st <= S_READ;
          end else begin
            delivered_count <= count;
            if (count == 8'd0) delivered_first <= '0;
            st <= S_OUT;
          end
        end
        S_OUT: if (!res_valid || res_taken) begin
          res_valid <= 1'b1; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

@@ design/arq_receiver_with_frame_check_top.sv @@
// arq_receiver_with_frame_check_top: stream wrapper around the check and arq engine
// depends on arqr_pkg, arqr_check, arqr_engine
//
// usage:
//   s_axis carries frame bytes, tdata = data_byte, tlast = last_byte.
//   m_axis carries one result per frame, tdata = {count, first, good, seq, kind}
//   packed from bit 0, tuser unused. configuration goes through cfg_we/cfg_index/
//   cfg_data while the block is idle.
// throughput: one byte per cycle within a frame. a frame end is held off while
//   the engine works on the previous frame or its result is still waiting.
// result path: check verdict register, engine S_OUT state, output register; a
//   selective-repeat frame that lands in the window first walks the map in S_READ
//   and S_TEST per frame delivered (up to 128), bound by its single read port.
// reset: synchronous; afterwards the received map is cleared entry by entry,
//   during which no byte is taken.
// stall: a result waits in the output register; when m_axis_tready stays low
//   the engine holds and input stops at the next frame end.
module arq_receiver_with_frame_check_top #(
  parameter int SEQ_SPACE = 256,
  parameter int SEQ_BYTE_POS = 14,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // reply_kind, reply_seq, frame_good, first, count
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import arqr_pkg::*;
  logic [1:0] arq_mode;
  logic [2:0] check_scheme;
  logic [7:0] window_size;
  frame_end_t fe;
  logic busy, pend;
  logic [1:0] kind;
  logic [7:0] rseq, first, cnt;
  logic good;
  logic busy_clr;
  logic rst_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      arq_mode <= MODE_SW; check_scheme <= SCH_SUM; window_size <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: arq_mode <= cfg_data[1:0];
        REG_SCHEME: check_scheme <= cfg_data[2:0];
        REG_WINDOW: window_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off a frame end while the previous one is still in the engine
  assign pend = fe.done || busy;
  assign s_axis_tready = !(pend && s_axis_tlast) && !busy_clr;
  assign busy_clr = busy && !fe.done && rst_phase;
  always_ff @(posedge clk) begin
    if (rst) rst_phase <= 1'b1;
    else if (!busy) rst_phase <= 1'b0;
  end

  arqr_check #(.SEQ_BYTE_POS(SEQ_BYTE_POS), .MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_check (
    .clk, .rst, .byte_valid(s_axis_tvalid && s_axis_tready),
    .data_byte(s_axis_tdata), .last_byte(s_axis_tlast), .check_scheme, .fe);

  arqr_engine #(.SEQ_SPACE(SEQ_SPACE)) u_engine (
    .clk, .rst, .fe, .arq_mode, .window_size, .busy,
    .res_valid(m_axis_tvalid), .res_taken(m_axis_tready),
    .reply_kind(kind), .reply_seq(rseq), .frame_good(good),
    .delivered_first(first), .delivered_count(cnt));

  assign m_axis_tdata = {5'd0, cnt, first, good, rseq, kind};
endmodule

@@ verif/tb_arq_receiver_with_frame_check_top.sv @@
// tb_arq_receiver_with_frame_check_top: self-checking bench for the arq receiver
// drives frames through the byte stream and checks every reply against its own predictor
// depends on arqr_pkg and arq_receiver_with_frame_check_top
module tb_arq_receiver_with_frame_check_top;
  timeunit 1ns;
  timeprecision 1ps;
  import arqr_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE = 300;
  localparam int MAX_BYTES = 2048;
  localparam int SEQ_POS = 14;

  typedef struct packed {
    logic [7:0] count;
    logic [7:0] first;
    logic       good;
    logic [7:0] rseq;
    logic [1:0] kind;
  } reply_t;

  class arq_scoreboard;
    logic [1:0] mode;
    logic [2:0] scheme;
    logic [7:0] window;
    logic [7:0] exp_seq;
    bit         rx_map[256];
    logic [31:0] crc;
    logic [15:0] sum;
    logic [15:0] held;
    int unsigned idx;
    logic [7:0] fseq;
    reply_t     replies[$];
    int         errors;
    int         seen;

    function void reset_all();
      mode = MODE_SW;
      scheme = SCH_SUM;
      window = 8'd4;
      exp_seq = 8'd0;
      foreach (rx_map[i]) rx_map[i] = 1'b0;
      errors = 0;
      seen = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      crc = 0;
      sum = 0;
      held = 0;
      idx = 0;
      fseq = 0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] r, logic [7:0] b, logic [2:0] sch);
      int deg;
      logic [31:0] poly;
      logic [31:0] mask;
      logic top;
      case (sch)
        SCH_CRC8: begin deg = 8; poly = 32'h0d5; end
        SCH_CRC10: begin deg = 10; poly = 32'h232; end
        SCH_CRC16: begin deg = 16; poly = 32'h8005; end
        SCH_CRC32: begin deg = 32; poly = 32'h04c11db7; end
        default: return r;
      endcase
      mask = (deg == 32) ? 32'hffffffff : ((32'd1 << deg) - 1);
      for (int i = 7; i >= 0; i--) begin
        top = r[deg-1];
        r = ((r << 1) | b[i]) & mask;
        if (top) r = r ^ poly;
      end
      return r;
    endfunction

    function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = a + b;
      if (s[16]) s = s[15:0] + 1;
      return s[15:0];
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      reply_t r;
      logic good;
      logic [7:0] old;
      int unsigned cur;
      int w;
      cur = idx;
      if (cur >= 2) begin
        old = held[15:8];
        sum = ones_add(sum, ((cur - 2) % 2) ? {8'h00, old} : {old, 8'h00});
      end
      held = {held[7:0], b};
      crc = crc_step(crc, b, scheme);
      if (cur == SEQ_POS) fseq = b;
      if (cur < MAX_BYTES) idx = cur + 1;
      if (!last) return;
      good = (cur >= SEQ_POS) && (cur < MAX_BYTES);
      if (good) begin
        if (scheme == SCH_SUM) good = (~sum) == held;
        else if (scheme <= SCH_CRC32) good = crc == 0;
        else good = 1'b0;
      end
      r = '{count: 8'd0, first: 8'd0, good: good, rseq: 8'd0, kind: KIND_NONE};
      case (mode)
        MODE_SW: begin
          r.kind = KIND_ACK;
          if (good) begin
            r.rseq = fseq;
            r.first = fseq;
            r.count = 1;
            exp_seq = {7'd0, ~exp_seq[0]};
          end else begin
            r.rseq = {7'd0, ~exp_seq[0]};
          end
        end
        MODE_GBN: begin
          if (good && fseq == exp_seq) begin
            r.first = fseq;
            r.count = 1;
            exp_seq = exp_seq + 1;
          end
          r.kind = KIND_ACK;
          r.rseq = exp_seq;
        end
        MODE_SR: begin
          r.rseq = fseq;
          if (!good) begin
            r.kind = KIND_NAK;
          end else begin
            r.kind = KIND_ACK;
            w = (window > 128) ? 128 : window;
            if (int'(8'(fseq - exp_seq)) < w) begin
              rx_map[fseq] = 1'b1;
              r.first = exp_seq;
              while (r.count < 128 && rx_map[exp_seq]) begin
                rx_map[exp_seq] = 1'b0;
                exp_seq = exp_seq + 1;
                r.count = r.count + 1;
              end
              if (r.count == 0) r.first = 0;
            end
          end
        end
        default: ;
      endcase
      replies = {replies, r};
      clear_frame();
    endfunction

    function void check_result(logic [31:0] d);
      reply_t got;
      reply_t want;
      got = d[26:0];
      if (replies.size() == 0) begin
        $error("reply with nothing outstanding: %h", d);
        errors++;
        return;
      end
      want = replies.pop_front();
      seen++;
      if (got.kind !== want.kind) begin
        $error("reply_kind expected %0d got %0d", want.kind, got.kind); errors++;
      end
      if (got.rseq !== want.rseq) begin
        $error("reply_seq expected %0d got %0d", want.rseq, got.rseq); errors++;
      end
      if (got.good !== want.good) begin
        $error("frame_good expected %0d got %0d", want.good, got.good); errors++;
      end
      if (got.first !== want.first) begin
        $error("delivered_first expected %0d got %0d", want.first, got.first); errors++;
      end
      if (got.count !== want.count) begin
        $error("delivered_count expected %0d got %0d", want.count, got.count); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // kind, seq, good, first, count
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  arq_receiver_with_frame_check_top DUT (.*);

  arq_scoreboard frames_sb;
  int  cycles;
  bit  no_idle;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // reply side: random stall after each taken reply, one long hold on demand
  initial begin
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        frames_sb.check_result(m_axis_tdata);
        stall = no_idle ? 0 : $urandom_range(0, 19);
      end else if (stall > 0) begin
        stall--;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 3000;
      end
      m_axis_tready <= (stall == 0);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    frames_sb.note_byte(b, last);
  endtask

  task automatic send_frame(logic [7:0] fr[$]);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  // appends a correct check field for the current scheme, or two random bytes for an unknown one
  task automatic add_tail(ref logic [7:0] fr[$]);
    logic [15:0] s;
    logic [31:0] r;
    int nb;
    s = 0;
    r = 0;
    if (frames_sb.scheme == SCH_SUM) begin
      for (int i = 0; i < fr.size(); i++)
        s = frames_sb.ones_add(s, (i % 2) ? {8'h00, fr[i]} : {fr[i], 8'h00});
      s = ~s;
      fr = {fr, s[15:8], s[7:0]};
    end else if (frames_sb.scheme <= SCH_CRC32) begin
      nb = (frames_sb.scheme == SCH_CRC8) ? 1 : (frames_sb.scheme == SCH_CRC32) ? 4 : 2;
      foreach (fr[i]) r = frames_sb.crc_step(r, fr[i], frames_sb.scheme);
      repeat (nb) r = frames_sb.crc_step(r, 8'h00, frames_sb.scheme);
      for (int j = nb - 1; j >= 0; j--) fr = {fr, r[8*j +: 8]};
    end else begin
      fr = {fr, 8'($urandom), 8'($urandom)};
    end
  endtask

  task automatic random_frame(int body_len);
    logic [7:0] fr[$];
    logic [7:0] seq;
    int pick;
    int w;
    int pos;
    pick = $urandom_range(0, 99);
    w = frames_sb.window;
    case (frames_sb.mode)
      MODE_SW: seq = ($urandom_range(0, 3) != 0) ? frames_sb.exp_seq : $urandom_range(0, 1);
      MODE_GBN: seq = ($urandom_range(0, 3) != 0) ? frames_sb.exp_seq : $urandom;
      default: seq = ($urandom_range(0, 4) != 0) ?
                     8'(frames_sb.exp_seq + $urandom_range(0, w + 2)) : $urandom;
    endcase
    if (pick < 10) begin
      // too short to hold a sequence number
      repeat ($urandom_range(1, SEQ_POS)) fr = {fr, 8'($urandom)};
    end else begin
      repeat (body_len) fr = {fr, 8'($urandom)};
      fr[SEQ_POS] = seq;
      add_tail(fr);
      if (pick < 25) begin
        pos = $urandom_range(0, fr.size() - 1);
        fr[pos] = fr[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
    end
    send_frame(fr);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (frames_sb.replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      REG_MODE: frames_sb.mode = value[1:0];
      REG_SCHEME: frames_sb.scheme = value[2:0];
      default: frames_sb.window = value;
    endcase
  endtask

  task automatic directed_frame(logic [7:0] fill, logic [7:0] seq);
    logic [7:0] fr[$];
    repeat (16) fr = {fr, fill};
    fr[SEQ_POS] = seq;
    add_tail(fr);
    send_frame(fr);
  endtask

  initial begin
    logic [1:0] modes[12];
    logic [2:0] schemes[12];
    logic [7:0] windows[12];
    logic [7:0] fr[$];
    modes = '{MODE_SW, MODE_GBN, MODE_SR, MODE_SR, MODE_SR, 2'd3,
              MODE_SR, MODE_GBN, MODE_SR, MODE_SW, MODE_GBN, MODE_SR};
    schemes = '{SCH_SUM, SCH_CRC8, SCH_CRC10, SCH_CRC16, SCH_CRC32, SCH_SUM,
                3'd7, SCH_CRC32, SCH_CRC8, SCH_CRC16, 3'd5, SCH_SUM};
    windows = '{8'd4, 8'd4, 8'd1, 8'd128, 8'd255, 8'd0,
                8'd8, 8'd16, 8'd0, 8'd64, 8'd2, 8'd32};
    frames_sb = new();
    frames_sb.reset_all();
    no_idle = 1'b0;
    hold_req = 1'b0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= 8'h00;
    s_axis_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MODE;
    cfg_data <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE) @(posedge clk);

    // byte extremes, a one-byte frame and a frame one short of the sequence byte
    directed_frame(8'h00, 8'h00);
    directed_frame(8'hff, 8'h01);
    fr = {8'h5a};
    send_frame(fr);
    fr = {};
    repeat (SEQ_POS) fr = {fr, 8'ha5};
    send_frame(fr);

    for (int ph = 0; ph < 12; ph++) begin
      drain();
      write_reg(REG_MODE, {6'd0, modes[ph]});
      write_reg(REG_SCHEME, {5'd0, schemes[ph]});
      write_reg(REG_WINDOW, windows[ph]);
      cfg_we <= 1'b0;
      no_idle = (ph % 3 == 2);
      if (ph == 4) hold_req = 1'b1;
      repeat (2) random_frame($urandom_range(SEQ_POS + 1, 24));
    end
    drain();
    if (frames_sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
